// ===== sv/ecsf_pkg.sv =====
// Package for the earliest common slot finder.
// Holds the list depth, the payload structs and the list control struct.
// No dependencies.
package ecsf_pkg;
    localparam int LIST_DEPTH = 16;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    typedef struct packed {
        logic [30:0] slot_start;
        logic [30:0] slot_end;
    } t_slot;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [30:0] slot_start;
        logic [30:0] slot_end;
    } t_in;

    typedef struct packed {
        logic        found;
        logic [30:0] meet_start;
        logic [31:0] meet_end;
        logic        overflowed;
    } t_out;

    typedef struct packed {
        logic ins;
        logic pop;
        logic clr;
    } t_list_ctl;
endpackage

// ===== sv/ecsf_cell.sv =====
// One entry of a sorted slot list.
// Inserts in order, shifts toward the head on pop. Uses ecsf_pkg.
module ecsf_cell (
    input  logic           i_clk,
    input  logic           i_valid,
    input  logic           i_ins,
    input  logic           i_pop,
    input  ecsf_pkg::t_slot i_new,
    input  ecsf_pkg::t_slot i_left,
    input  logic           i_left_lt,
    input  ecsf_pkg::t_slot i_right,
    output ecsf_pkg::t_slot o_slot,
    output logic           o_lt
);
    import ecsf_pkg::*;

    t_slot r_slot;
    t_slot n_slot;

    // new key sorts before this entry; empty entries sort last
    assign o_lt = !i_valid ||
                  (i_new.slot_start < r_slot.slot_start) ||
                  ((i_new.slot_start == r_slot.slot_start) &&
                   (i_new.slot_end < r_slot.slot_end));
    assign o_slot = r_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_pop) begin
            n_slot = i_right;
        end else if (i_ins) begin
            if (i_left_lt) begin
                n_slot = i_left;
            end else if (o_lt) begin
                n_slot = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end
endmodule

// ===== sv/ecsf_list.sv =====
// Sorted slot list: a chain of ecsf_cell with a fill count.
// Head of the chain is the smallest entry. Uses ecsf_pkg, ecsf_cell.
module ecsf_list (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ecsf_pkg::t_list_ctl i_ctl,
    input  ecsf_pkg::t_slot     i_new,
    output ecsf_pkg::t_slot     o_head,
    output logic               o_empty,
    output logic               o_full
);
    import ecsf_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    t_slot            w_slot [LIST_DEPTH];
    logic             w_lt   [LIST_DEPTH];
    logic             w_ins;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(LIST_DEPTH));
    assign w_ins   = i_ctl.ins && !o_full;
    assign o_head  = w_slot[0];

    for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
        t_slot w_left;
        t_slot w_right;
        logic  w_left_lt;
        if (k == 0) begin : g_first
            assign w_left    = w_slot[0];
            assign w_left_lt = 1'b0;
        end else begin : g_mid
            assign w_left    = w_slot[k-1];
            assign w_left_lt = w_lt[k-1];
        end
        if (k == LIST_DEPTH - 1) begin : g_last
            assign w_right = w_slot[k];
        end else begin : g_inner
            assign w_right = w_slot[k+1];
        end
        ecsf_cell u_cell (
            .i_clk     (i_clk),
            .i_valid   (r_cnt > CNT_W'(k)),
            .i_ins     (w_ins),
            .i_pop     (i_ctl.pop),
            .i_new     (i_new),
            .i_left    (w_left),
            .i_left_lt (w_left_lt),
            .i_right   (w_right),
            .o_slot    (w_slot[k]),
            .o_lt      (w_lt[k])
        );
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_ctl.clr) begin
            n_cnt = '0;
        end else if (i_ctl.pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end else if (w_ins) begin
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end
endmodule

// ===== sv/earliest_common_slot_finder.sv =====
// Earliest common slot finder: two sorted cell chains walked from the head.
// Loads are taken one per cycle while no compute is busy. A compute walks the heads,
// one head pop per walk step, until a hit or an empty list; input stalls meanwhile.
// Result in an output register; the next load is taken while it waits.
// Synchronous active-low reset empties both lists, meeting_length = 1.
module earliest_common_slot_finder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ecsf_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ecsf_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [30:0]   i_cfg_data
);
    import ecsf_pkg::*;

    logic [30:0] r_len;
    logic        r_busy;
    logic        r_drop;
    logic        r_out_valid;
    t_out        r_out;

    t_list_ctl w_ctl_a, w_ctl_b;
    t_slot     w_head_a, w_head_b, w_new;
    logic      w_empty_a, w_empty_b, w_full_a, w_full_b;
    logic      w_acc, w_out_free, w_done, w_hit;
    logic [30:0] w_lo, w_hi;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_acc       = i_in_valid && !r_busy;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_new       = '{slot_start: i_in_data.slot_start, slot_end: i_in_data.slot_end};

    assign w_lo  = (w_head_a.slot_start > w_head_b.slot_start) ?
                   w_head_a.slot_start : w_head_b.slot_start;
    assign w_hi  = (w_head_a.slot_end < w_head_b.slot_end) ?
                   w_head_a.slot_end : w_head_b.slot_end;
    assign w_hit = !w_empty_a && !w_empty_b && (w_hi >= w_lo) &&
                   ((w_hi - w_lo) >= r_len);
    assign w_done = r_busy && w_out_free && (w_empty_a || w_empty_b || w_hit);

    always_comb begin
        w_ctl_a.ins = w_acc && (i_in_data.opcode == OP_LOAD_A);
        w_ctl_b.ins = w_acc && (i_in_data.opcode == OP_LOAD_B);
        w_ctl_a.clr = w_done;
        w_ctl_b.clr = w_done;
        w_ctl_a.pop = r_busy && !w_done && !w_empty_a && !w_empty_b && !w_hit &&
                      (w_head_a.slot_end < w_head_b.slot_end);
        w_ctl_b.pop = r_busy && !w_done && !w_empty_a && !w_empty_b && !w_hit &&
                      !(w_head_a.slot_end < w_head_b.slot_end);
    end

    ecsf_list u_list_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl_a), .i_new(w_new),
        .o_head(w_head_a), .o_empty(w_empty_a), .o_full(w_full_a)
    );

    ecsf_list u_list_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl_b), .i_new(w_new),
        .o_head(w_head_b), .o_empty(w_empty_b), .o_full(w_full_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= 31'd1;
            r_busy      <= 1'b0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_len <= i_cfg_data;
            end
            if (w_acc && (i_in_data.opcode == OP_COMPUTE)) begin
                r_busy <= 1'b1;
            end
            if ((w_ctl_a.ins && w_full_a) || (w_ctl_b.ins && w_full_b)) begin
                r_drop <= 1'b1;
            end
            if (w_done) begin
                r_busy      <= 1'b0;
                r_drop      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out.found      <= w_hit;
            r_out.meet_start <= w_hit ? w_lo : 31'd0;
            r_out.meet_end   <= w_hit ? ({1'b0, w_lo} + {1'b0, r_len}) : 32'd0;
            r_out.overflowed <= r_drop;
        end
    end
endmodule

// ===== sv/ecsf_checker.sv =====
// Port-level checks for earliest_common_slot_finder, bound to the top level.
// Uses ecsf_pkg.
module ecsf_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input ecsf_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input ecsf_pkg::t_out o_out_data
);
    import ecsf_pkg::*;

    a_compute_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.opcode == OP_COMPUTE) |=> o_in_stall)
        else $error("compute transaction did not stall input");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found) |->
        (o_out_data.meet_start == 31'd0 && o_out_data.meet_end == 32'd0))
        else $error("no-slot result with nonzero times");

    a_result_from_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without compute");
endmodule

bind earliest_common_slot_finder ecsf_checker u_ecsf_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_stall(o_in_stall), .i_in_data(i_in_data), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_out_data(o_out_data)
);

// ===== tb/earliest_common_slot_finder_tb.sv =====
// Testbench for earliest_common_slot_finder: loads random calendars and checks each
// compute result against an in-bench slot intersection predictor.
// Depends on ecsf_pkg and the earliest_common_slot_finder RTL.
module earliest_common_slot_finder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ecsf_pkg::*;

    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [30:0] i_cfg_data = '0;

    earliest_common_slot_finder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_in  slot_queue[$];
    t_out meeting_queue[$];
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   errors = 0;
    int   item_count = 0;
    bit   in_fire = 1'b0;
    bit   hold_go = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_left = 0;
    int   quiet_cycles = 0;

    // predictor state
    bit [30:0] cal_a_st[LIST_DEPTH], cal_a_en[LIST_DEPTH];
    bit [30:0] cal_b_st[LIST_DEPTH], cal_b_en[LIST_DEPTH];
    int        cnt_a = 0, cnt_b = 0;
    bit        dropped = 1'b0;
    bit [30:0] meet_len = 31'd1;

    task automatic sort_calendar(inout bit [30:0] st[LIST_DEPTH],
                                 inout bit [30:0] en[LIST_DEPTH], input int cnt);
        bit [30:0] s, e;
        int p;
        for (int k = 1; k < cnt; k++) begin
            s = st[k];
            e = en[k];
            p = k;
            while (p > 0 && (st[p-1] > s || (st[p-1] == s && en[p-1] > e))) begin
                st[p] = st[p-1];
                en[p] = en[p-1];
                p--;
            end
            st[p] = s;
            en[p] = e;
        end
    endtask

    task automatic predict_meeting(input t_in item);
        t_out r;
        int i, j;
        bit [30:0] lo, hi;
        case (item.opcode)
            OP_LOAD_A: begin
                if (cnt_a >= LIST_DEPTH) dropped = 1'b1;
                else begin
                    cal_a_st[cnt_a] = item.slot_start;
                    cal_a_en[cnt_a] = item.slot_end;
                    cnt_a++;
                end
            end
            OP_LOAD_B: begin
                if (cnt_b >= LIST_DEPTH) dropped = 1'b1;
                else begin
                    cal_b_st[cnt_b] = item.slot_start;
                    cal_b_en[cnt_b] = item.slot_end;
                    cnt_b++;
                end
            end
            OP_COMPUTE: begin
                r = '0;
                sort_calendar(cal_a_st, cal_a_en, cnt_a);
                sort_calendar(cal_b_st, cal_b_en, cnt_b);
                i = 0;
                j = 0;
                while (i < cnt_a && j < cnt_b) begin
                    lo = (cal_a_st[i] > cal_b_st[j]) ? cal_a_st[i] : cal_b_st[j];
                    hi = (cal_a_en[i] < cal_b_en[j]) ? cal_a_en[i] : cal_b_en[j];
                    if (hi >= lo && hi - lo >= meet_len) begin
                        r.found = 1'b1;
                        r.meet_start = lo;
                        r.meet_end = {1'b0, lo} + {1'b0, meet_len};
                        break;
                    end
                    if (cal_a_en[i] < cal_b_en[j]) i++;
                    else j++;
                end
                r.overflowed = dropped;
                meeting_queue.push_back(r);
                cnt_a = 0;
                cnt_b = 0;
                dropped = 1'b0;
            end
            default: ;
        endcase
    endtask

    // monitor and predictor
    always @(posedge i_clk) begin
        t_out want;
        in_fire = i_rst_n && i_in_valid && !o_in_stall;
        if (in_fire) predict_meeting(i_in_data);
        if (i_rst_n && i_cfg_valid && o_cfg_ready) meet_len = i_cfg_data;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (meeting_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %p", $time, o_out_data);
            end else begin
                want = meeting_queue.pop_front();
                if (want.found !== o_out_data.found ||
                    want.meet_start !== o_out_data.meet_start ||
                    want.meet_end !== o_out_data.meet_end ||
                    want.overflowed !== o_out_data.overflowed) begin
                    errors++;
                    $display("%0t: expected %p actual %p", $time, want, o_out_data);
                end
            end
        end
        if (in_fire || (o_out_valid && !i_out_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (slot_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_data <= slot_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 400;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic add_item(input logic [1:0] op, input bit [30:0] s, input bit [30:0] e);
        slot_queue.push_back('{opcode: op, slot_start: s, slot_end: e});
        if (op != OP_IGNORED) item_count++;
    endtask

    function automatic bit [30:0] rand_time();
        if ($urandom_range(7) == 0) return 31'($urandom);
        return 31'($urandom_range(0, 300));
    endfunction

    task automatic add_slot(input logic [1:0] op);
        bit [30:0] s, e;
        s = rand_time();
        if ($urandom_range(9) == 0) e = (s == 0) ? 31'($urandom) : 31'($urandom_range(0, s - 1));
        else if ($urandom_range(15) == 0) e = 31'($urandom);
        else e = s + 31'($urandom_range(0, 80));
        add_item(op, s, e);
    endtask

    task automatic add_calendars(input int target);
        int na, nb;
        while (item_count < target) begin
            if ($urandom_range(9) == 0) begin
                // noise: ignored opcode, stray loads, or a bare compute
                case ($urandom_range(2))
                    0: add_item(OP_IGNORED, 31'($urandom), 31'($urandom));
                    1: add_slot(2'($urandom_range(1)));
                    default: add_item(OP_COMPUTE, 31'($urandom), 31'($urandom));
                endcase
            end else begin
                na = ($urandom_range(9) == 0) ? $urandom_range(LIST_DEPTH, LIST_DEPTH + 3)
                                              : $urandom_range(0, 6);
                nb = ($urandom_range(9) == 0) ? $urandom_range(LIST_DEPTH, LIST_DEPTH + 3)
                                              : $urandom_range(0, 6);
                while (na > 0 || nb > 0) begin
                    if (nb == 0 || (na > 0 && $urandom_range(1))) begin
                        add_slot(OP_LOAD_A);
                        na--;
                    end else begin
                        add_slot(OP_LOAD_B);
                        nb--;
                    end
                end
                add_item(OP_COMPUTE, 31'($urandom), 31'($urandom));
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (slot_queue.size() > 0 || i_in_valid || meeting_queue.size() > 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_meet_len(input bit [30:0] v);
        wait_drained();
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset meeting length
        add_item(OP_COMPUTE, 31'h7FFFFFFF, 31'h7FFFFFFF);
        add_item(OP_LOAD_A, 31'd10, 31'd20);
        add_item(OP_COMPUTE, '0, '0);
        add_item(OP_LOAD_A, 31'd10, 31'd20);
        add_item(OP_LOAD_B, 31'd15, 31'd30);
        add_item(OP_LOAD_B, 31'd9, 31'd5);
        add_item(OP_IGNORED, 31'd1, 31'd2);
        add_item(OP_COMPUTE, '0, '0);
        for (int k = 0; k <= LIST_DEPTH; k++)
            add_item(OP_LOAD_A, 31'(k * 3), 31'(k * 3 + 1));
        add_item(OP_LOAD_B, 31'd20, 31'd21);
        add_item(OP_COMPUTE, '0, '0);
        write_meet_len(31'h7FFFFFFF);
        add_item(OP_LOAD_A, '0, 31'h7FFFFFFF);
        add_item(OP_LOAD_B, '0, 31'h7FFFFFFF);
        add_item(OP_COMPUTE, '0, '0);
        write_meet_len(31'd0);
        add_item(OP_LOAD_A, 31'h7FFFFFFF, 31'h7FFFFFFF);
        add_item(OP_LOAD_B, 31'h7FFFFFFF, 31'h7FFFFFFF);
        add_item(OP_COMPUTE, '0, '0);

        send_idle_pct = 28;
        recv_stall_pct = 80;
        add_calendars(item_count + 100);
        hold_go = 1'b1;
        add_calendars(item_count + 420);
        write_meet_len(31'd5);
        send_idle_pct = 80;
        recv_stall_pct = 28;
        add_calendars(item_count + 520);
        write_meet_len(31'($urandom_range(1, 40)));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        add_calendars(item_count + 480);
        wait_drained();

        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
